### sv/pdd_pkg.sv
// Package for the pixel depth deprojection block.
// Holds payload and configuration types, register codes, widths and fixed-point helpers.
// Standalone; imported by every pdd module and by the top level.
package pdd_pkg;

  localparam int NW = 41;  // normalised coordinate, Q.28
  localparam int QW = 36;  // product of two Q3.28 operands, Q.28
  localparam int CW = 48;  // clamp input width

  localparam logic signed [CW-1:0] Q3Max = 48'sd2147483647;
  localparam logic signed [CW-1:0] Q3Min = -48'sd2147483648;
  localparam logic signed [37:0]   Q28One = 38'sd268435456;
  localparam logic signed [33:0]   PtMax = 34'sd134217727;
  localparam logic signed [33:0]   PtMin = -34'sd134217728;

  typedef enum logic [3:0] {
    RegMode      = 4'd0,
    RegPrincipal = 4'd1,
    RegFocal     = 4'd2,
    RegK1        = 4'd3,
    RegK2        = 4'd4,
    RegK3        = 4'd5,
    RegP1        = 4'd6,
    RegP2        = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [15:0] depth_mm;
  } in_t;

  typedef struct packed {
    logic signed [27:0] point_x;
    logic signed [27:0] point_y;
    logic [15:0]        point_z;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic               mode;
    logic [15:0]        ppx;
    logic [15:0]        ppy;
    logic [31:0]        rfx;
    logic [31:0]        rfy;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } cfg_t;

  typedef struct packed {
    logic [15:0]          depth;
    logic signed [NW-1:0] x;
    logic signed [NW-1:0] y;
  } norm_t;

  typedef struct packed {
    logic [15:0]          depth;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic                 sat;
  } proj_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } clamp_t;

  function automatic clamp_t clamp_q3(input logic signed [CW-1:0] v);
    clamp_t r;
    r.sat = 1'b0;
    r.val = v[31:0];
    if (v > Q3Max) begin
      r.sat = 1'b1;
      r.val = Q3Max[31:0];
    end else if (v < Q3Min) begin
      r.sat = 1'b1;
      r.val = Q3Min[31:0];
    end
    return r;
  endfunction

  // floor of a*b / 2^28
  function automatic logic signed [QW-1:0] qmul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] ae;
    logic signed [63:0] be;
    logic signed [63:0] p;
    ae = 64'(a);
    be = 64'(b);
    p  = ae * be;
    return p[63:28];
  endfunction

endpackage

### sv/pdd_normalize.sv
// Pixel normalisation: subtract principal point, multiply by focal reciprocals.
// Two register stages with per-stage valid and back-pressure; uses pdd_pkg.
module pdd_normalize (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pdd_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pdd_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pdd_pkg::norm_t out_data_o
);
  import pdd_pkg::*;

  logic [1:0] v_q;
  logic [2:0] rdy;

  logic signed [16:0] dx_q, dy_q;
  logic [15:0]        d0_q;
  norm_t              n_q;

  logic signed [16:0] dx_d, dy_d;
  logic signed [48:0] mx, my;

  always_comb begin
    rdy[2] = out_ready_i;
    rdy[1] = !v_q[1] || rdy[2];
    rdy[0] = !v_q[0] || rdy[1];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[1];
  assign out_data_o  = n_q;

  assign dx_d = $signed({1'b0, in_data_i.pixel_x}) - $signed({1'b0, cfg_i.ppx});
  assign dy_d = $signed({1'b0, in_data_i.pixel_y}) - $signed({1'b0, cfg_i.ppy});
  assign mx   = 49'(dx_q) * 49'($signed({1'b0, cfg_i.rfx}));
  assign my   = 49'(dy_q) * 49'($signed({1'b0, cfg_i.rfy}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      d0_q <= in_data_i.depth_mm;
    end
    if (rdy[1]) begin
      n_q.depth <= d0_q;
      n_q.x     <= mx[48:8];
      n_q.y     <= my[48:8];
    end
  end

endmodule

### sv/pdd_correct.sv
// Inverse Brown-Conrady correction pipeline, eight register stages.
// One Q3.28 product or sum step per stage; mode select at the last stage; uses pdd_pkg.
module pdd_correct (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pdd_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pdd_pkg::norm_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pdd_pkg::proj_t out_data_o
);
  import pdd_pkg::*;

  localparam int NS = 8;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  // carried fields, one set per stage up to the stage that uses them
  logic [15:0]          dp_q [NS-1];
  logic signed [NW-1:0] x_q  [NS-1];
  logic signed [NW-1:0] y_q  [NS-1];
  logic signed [31:0]   xc_q [NS-2];
  logic signed [31:0]   yc_q [NS-2];
  logic                 st_q [NS-1];

  logic signed [QW-1:0] s0_xx_q, s0_yy_q, s0_xy_q;
  logic signed [36:0]   s1_r2_q;
  logic signed [37:0]   s1_sx_q, s1_sy_q;
  logic signed [QW-1:0] s1_xy_q;
  logic signed [31:0]   s2_r2c_q;
  logic signed [QW-1:0] s2_r4_q, s2_a1_q;
  logic signed [QW-1:0] tx1_q [5], ty1_q [5], tx2_q [5], ty2_q [5];
  logic signed [QW-1:0] s3_r6_q, s3_a2_q;
  logic signed [QW-1:0] a1_q [2:3];
  logic signed [QW-1:0] s4_a2_q, s4_a3_q;
  logic signed [37:0]   s5_f_q;
  logic signed [QW-1:0] s6_gx_q, s6_gy_q;
  proj_t                o_q;

  clamp_t xc, yc, r2c, sxc, syc, xyc, r4c, r6c, fc;
  logic signed [38:0] ux, uy;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign out_data_o  = o_q;

  always_comb begin
    xc  = clamp_q3(CW'(in_data_i.x));
    yc  = clamp_q3(CW'(in_data_i.y));
    r2c = clamp_q3(CW'(s1_r2_q));
    sxc = clamp_q3(CW'(s1_sx_q));
    syc = clamp_q3(CW'(s1_sy_q));
    xyc = clamp_q3(CW'(s1_xy_q));
    r4c = clamp_q3(CW'(s2_r4_q));
    r6c = clamp_q3(CW'(s3_r6_q));
    fc  = clamp_q3(CW'(s5_f_q));
    ux  = 39'(s6_gx_q) + (39'(tx1_q[4]) <<< 1) + 39'(tx2_q[4]);
    uy  = 39'(s6_gy_q) + (39'(ty1_q[4]) <<< 1) + 39'(ty2_q[4]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // carried fields
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      dp_q[0] <= in_data_i.depth;
      x_q[0]  <= in_data_i.x;
      y_q[0]  <= in_data_i.y;
      xc_q[0] <= xc.val;
      yc_q[0] <= yc.val;
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (rdy[k]) begin
        dp_q[k] <= dp_q[k-1];
        x_q[k]  <= x_q[k-1];
        y_q[k]  <= y_q[k-1];
      end
    end
    for (int k = 1; k < NS - 2; k++) begin
      if (rdy[k]) begin
        xc_q[k] <= xc_q[k-1];
        yc_q[k] <= yc_q[k-1];
      end
    end
  end

  // saturation flags of the correction products
  always_ff @(posedge clk_i) begin
    if (rdy[0]) st_q[0] <= xc.sat | yc.sat;
    if (rdy[1]) st_q[1] <= st_q[0];
    if (rdy[2]) st_q[2] <= st_q[1] | r2c.sat | sxc.sat | syc.sat | xyc.sat;
    if (rdy[3]) st_q[3] <= st_q[2] | r4c.sat;
    if (rdy[4]) st_q[4] <= st_q[3] | r6c.sat;
    if (rdy[5]) st_q[5] <= st_q[4];
    if (rdy[6]) st_q[6] <= st_q[5] | fc.sat;
  end

  always_ff @(posedge clk_i) begin
    // x^2, y^2, xy
    if (rdy[0]) begin
      s0_xx_q <= qmul(xc.val, xc.val);
      s0_yy_q <= qmul(yc.val, yc.val);
      s0_xy_q <= qmul(xc.val, yc.val);
    end
    // r^2 and the tangential sums
    if (rdy[1]) begin
      s1_r2_q <= 37'(s0_xx_q) + 37'(s0_yy_q);
      s1_sx_q <= 38'(37'(s0_xx_q) + 37'(s0_yy_q)) + (38'(s0_xx_q) <<< 1);
      s1_sy_q <= 38'(37'(s0_xx_q) + 37'(s0_yy_q)) + (38'(s0_yy_q) <<< 1);
      s1_xy_q <= s0_xy_q;
    end
    // r^4, k1 term, tangential products
    if (rdy[2]) begin
      s2_r2c_q <= r2c.val;
      s2_r4_q  <= qmul(r2c.val, r2c.val);
      s2_a1_q  <= qmul(cfg_i.k1, r2c.val);
      tx1_q[0] <= qmul(cfg_i.p1, xyc.val);
      ty1_q[0] <= qmul(cfg_i.p2, xyc.val);
      tx2_q[0] <= qmul(cfg_i.p2, sxc.val);
      ty2_q[0] <= qmul(cfg_i.p1, syc.val);
    end
    for (int k = 1; k < 5; k++) begin
      if (rdy[k+2]) begin
        tx1_q[k] <= tx1_q[k-1];
        ty1_q[k] <= ty1_q[k-1];
        tx2_q[k] <= tx2_q[k-1];
        ty2_q[k] <= ty2_q[k-1];
      end
    end
    // r^6, k2 term
    if (rdy[3]) begin
      s3_r6_q  <= qmul(r4c.val, s2_r2c_q);
      s3_a2_q  <= qmul(cfg_i.k2, r4c.val);
      a1_q[2]  <= s2_a1_q;
    end
    // k3 term
    if (rdy[4]) begin
      s4_a3_q <= qmul(cfg_i.k3, r6c.val);
      s4_a2_q <= s3_a2_q;
      a1_q[3] <= a1_q[2];
    end
    // radial factor
    if (rdy[5]) begin
      s5_f_q  <= Q28One + 38'(a1_q[3]) + 38'(s4_a2_q) + 38'(s4_a3_q);
    end
    // x*f, y*f
    if (rdy[6]) begin
      s6_gx_q <= qmul(xc_q[NS-3], fc.val);
      s6_gy_q <= qmul(yc_q[NS-3], fc.val);
    end
    if (rdy[7]) begin
      o_q.depth <= dp_q[NS-2];
      o_q.nx    <= cfg_i.mode ? NW'(ux) : x_q[NS-2];
      o_q.ny    <= cfg_i.mode ? NW'(uy) : y_q[NS-2];
      o_q.sat   <= cfg_i.mode & st_q[NS-2];
    end
  end

endmodule

### sv/pdd_project.sv
// Projection to camera space: depth times normalised coordinate, then clipping.
// Two register stages with per-stage valid and back-pressure; uses pdd_pkg.
module pdd_project (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pdd_pkg::proj_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pdd_pkg::out_t  out_data_o
);
  import pdd_pkg::*;

  logic [1:0] v_q;
  logic [2:0] rdy;

  logic signed [33:0] px_q, py_q;
  logic [15:0]        d0_q;
  logic               s0_q;
  out_t               o_q;

  logic signed [57:0] mx, my;
  logic               clip_x, clip_y;
  logic signed [33:0] cx, cy;

  always_comb begin
    rdy[2] = out_ready_i;
    rdy[1] = !v_q[1] || rdy[2];
    rdy[0] = !v_q[0] || rdy[1];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[1];
  assign out_data_o  = o_q;

  assign mx = 58'($signed({1'b0, in_data_i.depth})) * 58'(in_data_i.nx);
  assign my = 58'($signed({1'b0, in_data_i.depth})) * 58'(in_data_i.ny);

  always_comb begin
    clip_x = (px_q > PtMax) || (px_q < PtMin);
    clip_y = (py_q > PtMax) || (py_q < PtMin);
    cx = px_q;
    cy = py_q;
    if (px_q > PtMax) cx = PtMax;
    else if (px_q < PtMin) cx = PtMin;
    if (py_q > PtMax) cy = PtMax;
    else if (py_q < PtMin) cy = PtMin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      px_q <= mx[57:24];
      py_q <= my[57:24];
      d0_q <= in_data_i.depth;
      s0_q <= in_data_i.sat;
    end
    if (rdy[1]) begin
      o_q.point_x   <= cx[27:0];
      o_q.point_y   <= cy[27:0];
      o_q.point_z   <= d0_q;
      o_q.saturated <= s0_q | clip_x | clip_y;
    end
  end

endmodule

### sv/pixel_depth_deprojection_top.sv
// Top level of the pixel depth deprojection block: configuration registers,
// input skid register and the normalise, correct and project pipelines (pdd_pkg).
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+--------------------------------
//   in       | input     | in_valid/in_stall  | pixel_x, pixel_y, depth_mm
//   out      | output    | out_valid/out_stall| point_x, point_y, point_z, sat
//   cfg      | input     | cfg_valid/cfg_ready| register index, 64-bit data
//
// One transaction per cycle sustained while the output is not stalled; input to output passes
// two normalise, eight correction and two projection stages (skid passed while empty).
// Reset clears valid bits and configuration registers; payload is not reset.
// A stall holds the output; bubbles still close up and in_stall follows the skid register.
module pixel_depth_deprojection_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pdd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pdd_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [3:0]    cfg_index_i,
  input  logic [63:0]   cfg_data_i
);
  import pdd_pkg::*;

  cfg_t  cfg_q;
  logic  skid_v_q, skid_v_d;
  in_t   skid_q;

  logic  src_valid;
  in_t   src_data;
  logic  norm_ready, norm_valid;
  norm_t norm_data;
  logic  corr_ready, corr_valid;
  proj_t corr_data;
  logic  proj_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegMode:      cfg_q.mode <= cfg_data_i[0];
        RegPrincipal: begin
          cfg_q.ppx <= cfg_data_i[15:0];
          cfg_q.ppy <= cfg_data_i[31:16];
        end
        RegFocal: begin
          cfg_q.rfx <= cfg_data_i[31:0];
          cfg_q.rfy <= cfg_data_i[63:32];
        end
        RegK1:   cfg_q.k1 <= $signed(cfg_data_i[31:0]);
        RegK2:   cfg_q.k2 <= $signed(cfg_data_i[31:0]);
        RegK3:   cfg_q.k3 <= $signed(cfg_data_i[31:0]);
        RegP1:   cfg_q.p1 <= $signed(cfg_data_i[31:0]);
        RegP2:   cfg_q.p2 <= $signed(cfg_data_i[31:0]);
        default: ;
      endcase
    end
  end

  // input skid register
  assign in_stall_o = skid_v_q;
  assign src_valid  = skid_v_q | in_valid_i;
  assign src_data   = skid_v_q ? skid_q : in_data_i;

  always_comb begin
    skid_v_d = skid_v_q;
    if (norm_ready) skid_v_d = 1'b0;
    else if (in_valid_i && !skid_v_q) skid_v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) skid_v_q <= 1'b0;
    else skid_v_q <= skid_v_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !skid_v_q && !norm_ready) skid_q <= in_data_i;
  end

  pdd_normalize u_normalize (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (src_valid),
    .in_ready_o  (norm_ready),
    .in_data_i   (src_data),
    .out_valid_o (norm_valid),
    .out_ready_i (corr_ready),
    .out_data_o  (norm_data)
  );

  pdd_correct u_correct (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (norm_valid),
    .in_ready_o  (corr_ready),
    .in_data_i   (norm_data),
    .out_valid_o (corr_valid),
    .out_ready_i (proj_ready),
    .out_data_o  (corr_data)
  );

  pdd_project u_project (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (corr_valid),
    .in_ready_o  (proj_ready),
    .in_data_i   (corr_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(!norm_ready))
    else $error("skid register filled while pipeline could take the transaction");

  a_skid_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !norm_ready |=> skid_v_q)
    else $error("accepted transaction neither entered the pipeline nor the skid register");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && norm_ready |=> !skid_v_q)
    else $error("skid register not drained when pipeline was ready");

  a_no_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> norm_ready)
    else $error("pipeline blocked although output is not stalled");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for pixel_depth_deprojection_top (types from pdd_pkg).
// Drives configuration phases and pixel transactions with random gaps and stalls,
// and checks every point against a bit-exact predictor kept in a scoreboard class.

class deprojection_checker;
  logic          mode;
  logic [15:0]   ppx;
  logic [15:0]   ppy;
  logic [31:0]   rfx;
  logic [31:0]   rfy;
  int            k1;
  int            k2;
  int            k3;
  int            p1;
  int            p2;
  pdd_pkg::out_t expected_points[$];
  int            mismatches;

  function new();
    mode       = 1'b0;
    ppx        = '0;
    ppy        = '0;
    rfx        = '0;
    rfy        = '0;
    k1         = 0;
    k2         = 0;
    k3         = 0;
    p1         = 0;
    p2         = 0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [3:0] idx, logic [63:0] data);
    case (idx)
      pdd_pkg::RegMode:      mode = data[0];
      pdd_pkg::RegPrincipal: begin
        ppx = data[15:0];
        ppy = data[31:16];
      end
      pdd_pkg::RegFocal:     begin
        rfx = data[31:0];
        rfy = data[63:32];
      end
      pdd_pkg::RegK1:        k1 = int'(data[31:0]);
      pdd_pkg::RegK2:        k2 = int'(data[31:0]);
      pdd_pkg::RegK3:        k3 = int'(data[31:0]);
      pdd_pkg::RegP1:        p1 = int'(data[31:0]);
      pdd_pkg::RegP2:        p2 = int'(data[31:0]);
      default: ;
    endcase
  endfunction

  function longint clamp_q3(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // floor(a * b / 2^28) on operands clipped to Q3.28
  function longint qmul(longint a, longint b, inout bit sat);
    longint ca;
    longint cb;
    ca = clamp_q3(a, sat);
    cb = clamp_q3(b, sat);
    return (ca * cb) >>> 28;
  endfunction

  function longint to_point(longint dep, longint c, inout bit sat);
    longint p;
    p = (dep * c) >>> 24;
    if (p > 64'sd134217727) begin
      sat = 1'b1;
      return 64'sd134217727;
    end
    if (p < -64'sd134217728) begin
      sat = 1'b1;
      return -64'sd134217728;
    end
    return p;
  endfunction

  function pdd_pkg::out_t deproject(pdd_pkg::in_t px);
    longint        x;
    longint        y;
    longint        dep;
    longint        xx;
    longint        yy;
    longint        xy;
    longint        r2;
    longint        r4;
    longint        r6;
    longint        f;
    longint        ux;
    longint        uy;
    longint        ox;
    longint        oy;
    bit            sat;
    pdd_pkg::out_t r;
    sat = 1'b0;
    dep = longint'(px.depth_mm);
    x = ((longint'(px.pixel_x) - longint'(ppx)) * longint'(rfx)) >>> 8;
    y = ((longint'(px.pixel_y) - longint'(ppy)) * longint'(rfy)) >>> 8;
    if (mode) begin
      xx = qmul(x, x, sat);
      yy = qmul(y, y, sat);
      xy = qmul(x, y, sat);
      r2 = xx + yy;
      r4 = qmul(r2, r2, sat);
      r6 = qmul(r4, r2, sat);
      f  = 64'sd268435456 + qmul(k1, r2, sat) + qmul(k2, r4, sat) + qmul(k3, r6, sat);
      ux = qmul(x, f, sat) + 2 * qmul(p1, xy, sat) + qmul(p2, r2 + 2 * xx, sat);
      uy = qmul(y, f, sat) + 2 * qmul(p2, xy, sat) + qmul(p1, r2 + 2 * yy, sat);
      x  = ux;
      y  = uy;
    end
    ox = to_point(dep, x, sat);
    oy = to_point(dep, y, sat);
    r.point_x   = ox[27:0];
    r.point_y   = oy[27:0];
    r.point_z   = px.depth_mm;
    r.saturated = sat;
    return r;
  endfunction

  function void note_pixel(pdd_pkg::in_t px);
    expected_points = {expected_points, deproject(px)};
  endfunction

  task report(string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task check_point(pdd_pkg::out_t got);
    pdd_pkg::out_t want;
    if (expected_points.size() == 0) begin
      report($sformatf("unexpected point x=%0d y=%0d z=%0d sat=%0b",
                       got.point_x, got.point_y, got.point_z, got.saturated));
      return;
    end
    want = expected_points.pop_front();
    if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
        got.point_z !== want.point_z || got.saturated !== want.saturated) begin
      report($sformatf({"point mismatch: got x=%0d y=%0d z=%0d sat=%0b, ",
                        "exp x=%0d y=%0d z=%0d sat=%0b"},
                       got.point_x, got.point_y, got.point_z, got.saturated,
                       want.point_x, want.point_y, want.point_z, want.saturated));
    end
  endtask
endclass

module tb_top;
  import pdd_pkg::*;

  localparam int unsigned Limit      = 1_000_000;
  localparam logic [3:0]  RegSpareLo = 4'd8;
  localparam logic [3:0]  RegSpareHi = 4'd15;
  localparam logic [31:0] PpCentre   = {16'h0F00, 16'h1400};
  localparam logic [63:0] FocalTyp   = {32'd7158278, 32'd7158278};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [63:0] cfg_data;

  deprojection_checker chk;
  bit          no_idle;
  int unsigned stall_run;
  int unsigned cycle_cnt;

  pixel_depth_deprojection_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned gap_len();
    if (no_idle || $urandom_range(0, 99) < 55) return 0;
    return idle_len();
  endfunction

  function automatic in_t rand_pixel();
    in_t         p;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      p.pixel_x = 16'($urandom_range(0, 16'h4FFF));
      p.pixel_y = 16'($urandom_range(0, 16'h2FFF));
    end else begin
      p.pixel_x = 16'($urandom);
      p.pixel_y = 16'($urandom);
    end
    r = $urandom_range(0, 99);
    if (r < 5) p.depth_mm = 16'h0000;
    else if (r < 10) p.depth_mm = 16'hFFFF;
    else if (r < 60) p.depth_mm = 16'($urandom_range(200, 10000));
    else p.depth_mm = 16'($urandom);
    return p;
  endfunction

  function automatic logic [31:0] rand_coef();
    logic [31:0] c;
    c = $urandom;
    if ($urandom_range(0, 3) != 0) c = {{5{c[26]}}, c[26:0]};
    return c;
  endfunction

  // output stall: random bursts, no new ones while no_idle is set
  always @(negedge clk) begin
    if (stall_run == 0) begin
      if (no_idle || $urandom_range(0, 1) == 0) begin
        out_stall <= 1'b0;
        stall_run = no_idle ? 1 : $urandom_range(1, 8);
      end else begin
        out_stall <= 1'b1;
        stall_run = idle_len();
      end
    end
    stall_run--;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) chk.check_point(out_data);
      if (in_valid && !in_stall) chk.note_pixel(in_data);
      if (cfg_valid && cfg_ready) chk.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == Limit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic cfg_write(logic [3:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic m, logic [31:0] pp, logic [63:0] focal, logic [31:0] c1,
                            logic [31:0] c2, logic [31:0] c3, logic [31:0] c4,
                            logic [31:0] c5);
    cfg_write(RegMode, {32'($urandom), 31'($urandom), m});
    cfg_write(RegPrincipal, {32'($urandom), pp});
    cfg_write(RegFocal, focal);
    cfg_write(RegK1, {32'($urandom), c1});
    cfg_write(RegK2, {32'($urandom), c2});
    cfg_write(RegK3, {32'($urandom), c3});
    cfg_write(RegP1, {32'($urandom), c4});
    cfg_write(RegP2, {32'($urandom), c5});
  endtask

  task automatic send_pixel(in_t d);
    repeat (gap_len()) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_px(logic [15:0] x, logic [15:0] y, logic [15:0] d);
    in_t p;
    p.pixel_x  = x;
    p.pixel_y  = y;
    p.depth_mm = d;
    send_pixel(p);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_pixel(rand_pixel());
    end
    no_idle = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chk.expected_points.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] pp;
    logic [63:0] focal;
    chk       = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    no_idle   = 1'b0;
    stall_run = 0;
    cycle_cnt = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: zero reciprocals
    send_px(16'h0000, 16'h0000, 16'h0000);
    send_px(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_px(16'h1234, 16'h5678, 16'h9ABC);
    drain();

    set_config(1'b0, PpCentre, FocalTyp, 32'hF933_3333, 32'h0199_999A, 32'hFFD7_0A3D,
               32'h0004_1893, 32'hFFFD_F3B6);
    send_px(16'h1400, 16'h0F00, 16'hFFFF);
    send_px(16'h0000, 16'h0000, 16'hFFFF);
    send_px(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_px(16'hFFFF, 16'h0000, 16'h0001);
    send_px(16'h1401, 16'h0EFF, 16'h8000);
    send_px(16'h4FFF, 16'h2FFF, 16'h0000);
    send_px(16'h0001, 16'hFFFE, 16'h0001);
    send_px(16'h8000, 16'h7FFF, 16'h7FFF);
    run_random(100);
    drain();

    // clipping of the point in both directions
    set_config(1'b0, 32'h0000_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
               32'h0);
    send_px(16'h0000, 16'hFFFF, 16'hFFFF);
    send_px(16'hFFFF, 16'h0000, 16'hFFFF);
    send_px(16'h0100, 16'h0100, 16'h0001);
    run_random(80);
    drain();

    set_config(1'b1, PpCentre, FocalTyp, 32'hFB33_3333, 32'h0199_999A, 32'hFFD7_0A3D,
               32'h0004_1893, 32'hFFFD_F3B6);
    send_px(16'h1400, 16'h0F00, 16'h1000);
    send_px(16'h0000, 16'h0000, 16'h2000);
    send_px(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_px(16'h4FFF, 16'h2FFF, 16'hFFFF);
    run_random(120);
    drain();

    set_config(1'b1, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_px(16'h0000, 16'h0000, 16'hFFFF);
    send_px(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(60);
    drain();

    set_config(1'b1, PpCentre, FocalTyp, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000);
    send_px(16'h0000, 16'h0000, 16'hFFFF);
    send_px(16'h4FFF, 16'h2FFF, 16'h1000);
    run_random(60);
    drain();

    // coefficients left in place must have no effect without correction
    cfg_write(4'($urandom_range(RegSpareLo, RegSpareHi)), {32'($urandom), 32'($urandom)});
    cfg_write(RegMode, {32'($urandom), 31'($urandom), 1'b0});
    cfg_write(4'($urandom_range(RegSpareLo, RegSpareHi)), {32'($urandom), 32'($urandom)});
    run_random(80);
    drain();

    repeat (3) begin
      if ($urandom_range(0, 1) == 0)
        pp = {16'($urandom_range(0, 16'h2FFF)), 16'($urandom_range(0, 16'h4FFF))};
      else
        pp = $urandom;
      if ($urandom_range(0, 1) == 0)
        focal = {32'($urandom_range(32'h0040_0000, 32'h0100_0000)),
                 32'($urandom_range(32'h0040_0000, 32'h0100_0000))};
      else
        focal = {32'($urandom), 32'($urandom)};
      set_config(1'($urandom), pp, focal, rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                 rand_coef());
      run_random(70);
      drain();
    end

    repeat (30) @(posedge clk);
    if (chk.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

### sim.f
sv/pdd_pkg.sv
sv/pdd_normalize.sv
sv/pdd_correct.sv
sv/pdd_project.sv
sv/pixel_depth_deprojection_top.sv
tb/tb_top.sv
